// ===== hdl/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

  // Framing bytes and CRC-16 polynomial (MSB first, zero init).
  localparam logic [7:0]  SYNC_BYTE = 8'hFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // Header layout: FF FF, address, port, length, then payload.
  localparam int ADDR_IDX    = 2;
  localparam int PORT_IDX    = 3;
  localparam int LEN_IDX     = 4;
  localparam int PAYLOAD_OFS = 5;
  localparam int FRAME_EXTRA = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESYNC,
    ST_LEN_RD,
    ST_LEN_CHK,
    ST_CRC,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  // Load request for the output register, issued by the sequencer.
  typedef struct packed {
    logic       load;
    logic       last;
    logic       zero_byte;
    logic [7:0] src_addr;
    logic [7:0] src_port;
    logic [5:0] length;
  } emit_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/sfr_store.sv =====
`timescale 1ns / 1ps

module sfr_store #(
  parameter int DEPTH = 39,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sfr_seq.sv =====
`timescale 1ns / 1ps

module sfr_seq
  import sfr_pkg::*;
#(
  parameter int PAYLOAD_MAX = 32,
  parameter int AW          = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    rx_byte_i,
  output logic          in_stall_o,
  input  logic          out_free_i,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [7:0]    mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [7:0]    mem_rdata_i,
  output emit_t         emit_o
);

  localparam int DEPTH = PAYLOAD_MAX + FRAME_EXTRA;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int LENW  = $clog2(PAYLOAD_MAX + 1);

  state_e          state_q, state_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic            ff_q, ff_d;
  logic [LENW-1:0] len_q, len_d;
  logic [LENW-1:0] e_q, e_d;
  logic [AW-1:0]   k_q, k_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      lo_q, lo_d;
  logic [7:0]      addr_q, addr_d;
  logic [7:0]      port_q, port_d;

  logic          accept;
  logic [AW-1:0] pos_wrap;
  logic [PW-1:0] pos_inc;
  logic          len_ok;
  logic [8:0]    len9, k9;
  logic          crc_hdr_bad, crc_last, crc_lo, crc_data, crc_match;
  logic          emit_last;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign pos_wrap = (pos_q >= PW'(DEPTH)) ? '0 : pos_q[AW-1:0];
  assign pos_inc  = PW'(pos_wrap) + PW'(1);

  assign len_ok = (9'(mem_rdata_i) <= 9'(PAYLOAD_MAX)) &&
                  (9'(pos_q) == 9'(mem_rdata_i) + 9'(FRAME_EXTRA));

  assign len9        = 9'(len_q);
  assign k9          = 9'(k_q);
  assign crc_hdr_bad = ((k_q == AW'(0)) || (k_q == AW'(1))) && (mem_rdata_i != SYNC_BYTE);
  assign crc_data    = k9 < len9 + 9'(PAYLOAD_OFS);
  assign crc_lo      = k9 == len9 + 9'(PAYLOAD_OFS);
  assign crc_last    = k9 == len9 + 9'(PAYLOAD_OFS + 1);
  assign crc_match   = {mem_rdata_i, lo_q} == crc_q;
  assign emit_last   = (len_q == '0) || (e_q + LENW'(1) == len_q);

  // The input is held off for the whole frame check and payload burst, so the
  // store is never written while a read pass is walking it.
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (ff_q) begin
            if (rx_byte_i == SYNC_BYTE) begin
              state_d = ST_RESYNC;
            end
          end else if (pos_inc >= PW'(FRAME_EXTRA)) begin
            state_d = ST_LEN_RD;
          end
        end
      end
      ST_RESYNC:  state_d = ST_IDLE;
      ST_LEN_RD:  state_d = ST_LEN_CHK;
      ST_LEN_CHK: state_d = len_ok ? ST_CRC : ST_IDLE;
      ST_CRC: begin
        if (crc_hdr_bad) begin
          state_d = ST_IDLE;
        end else if (crc_last) begin
          state_d = crc_match ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        if (out_free_i) begin
          state_d = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    ff_d        = ff_q;
    len_d       = len_q;
    e_d         = e_q;
    k_d         = k_q;
    crc_d       = crc_q;
    lo_d        = lo_q;
    addr_d      = addr_q;
    port_d      = port_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_wrap;
    mem_wdata_o = rx_byte_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = k_q;
    emit_o      = '0;
    emit_o.src_addr  = addr_q;
    emit_o.src_port  = port_q;
    emit_o.length    = 6'(len_q);
    emit_o.zero_byte = (len_q == '0);
    emit_o.last      = emit_last;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d = PW'(pos_wrap);
          if (ff_q) begin
            // A byte after FF is never stored; only a second FF acts on the store.
            ff_d = 1'b0;
            if (rx_byte_i == SYNC_BYTE) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
              mem_wdata_o = SYNC_BYTE;
              pos_d       = PW'(ADDR_IDX);
            end
          end else begin
            ff_d     = (rx_byte_i == SYNC_BYTE);
            mem_we_o = 1'b1;
            pos_d    = pos_inc;
          end
        end
      end
      ST_RESYNC: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AW'(1);
        mem_wdata_o = SYNC_BYTE;
      end
      ST_LEN_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = AW'(LEN_IDX);
      end
      ST_LEN_CHK: begin
        len_d = mem_rdata_i[LENW-1:0];
        e_d   = '0;
        k_d   = '0;
        crc_d = '0;
        if (len_ok) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = '0;
        end
      end
      ST_CRC: begin
        if (k_q == AW'(ADDR_IDX)) begin
          addr_d = mem_rdata_i;
        end
        if (k_q == AW'(PORT_IDX)) begin
          port_d = mem_rdata_i;
        end
        if (crc_data) begin
          crc_d = crc16_byte(crc_q, mem_rdata_i);
        end
        if (crc_lo) begin
          lo_d = mem_rdata_i;
        end
        if (!crc_hdr_bad && !crc_last) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = k_q + AW'(1);
          k_d         = k_q + AW'(1);
        end
      end
      ST_EMIT_RD: begin
        mem_re_o    = out_free_i;
        mem_raddr_o = AW'(9'(e_q) + 9'(PAYLOAD_OFS));
      end
      ST_EMIT_LD: begin
        emit_o.load = 1'b1;
        e_d         = e_q + LENW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      ff_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      ff_q    <= ff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    e_q    <= e_d;
    k_q    <= k_d;
    crc_q  <= crc_d;
    lo_q   <= lo_d;
    addr_q <= addr_d;
    port_q <= port_d;
  end

endmodule

// ===== hdl/stuffed_frame_receiver_crc16.sv =====
`timescale 1ns / 1ps

// Byte-stuffed frame receiver with CRC-16/XMODEM check. Frames are FF FF,
// address, port, length, payload and a little-endian CRC over header and
// payload; a byte after FF is dropped, and FF FF restarts the frame, with
// both sync bytes written back to the frame memory. Each stored byte that
// brings the position to 7 or beyond also has the length byte read back
// from the frame memory. When the position reaches length + 7 the
// sequencer walks the frame memory once, one byte a cycle, to check the
// CRC, then reads the payload again, each beat read from the memory and
// then loaded into the output register, waiting while that register is
// not free. Input is stalled throughout. The memory needs no clearing after
// reset: only entries written since reset are ever read.
module stuffed_frame_receiver_crc16
  import sfr_pkg::*;
#(
  parameter int PAYLOAD_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] source_address_o,
  output logic [7:0] source_port_o,
  output logic [5:0] payload_length_o,
  output logic [7:0] payload_byte_o,
  output logic       last_of_frame_o
);

  localparam int DEPTH = PAYLOAD_MAX + FRAME_EXTRA;
  localparam int AW    = $clog2(DEPTH);

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  emit_t         emit;
  logic          out_free;

  logic       out_valid_q, out_valid_d;
  logic [7:0] addr_q, port_q, byte_q;
  logic [5:0] len_q;
  logic       last_q;

  sfr_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  sfr_seq #(
    .PAYLOAD_MAX(PAYLOAD_MAX),
    .AW         (AW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .emit_o     (emit)
  );

  // The register is free when empty or when its beat leaves at this edge.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      addr_q <= emit.src_addr;
      port_q <= emit.src_port;
      len_q  <= emit.length;
      byte_q <= emit.zero_byte ? 8'h00 : mem_rdata;
      last_q <= emit.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign source_address_o = addr_q;
  assign source_port_o    = port_q;
  assign payload_length_o = len_q;
  assign payload_byte_o   = byte_q;
  assign last_of_frame_o  = last_q;

endmodule

// ===== hdl/sfr_checker.sv =====
`timescale 1ns / 1ps

module sfr_checker #(
  parameter int PAYLOAD_MAX = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] source_address_o,
  input logic [7:0] source_port_o,
  input logic [5:0] payload_length_o,
  input logic [7:0] payload_byte_o,
  input logic       last_of_frame_o
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(source_address_o) && $stable(source_port_o)
      && $stable(payload_length_o) && $stable(payload_byte_o) && $stable(last_of_frame_o))
    else $error("stalled result beat changed");

  // Within a payload burst no new serial byte may be taken.
  a_burst_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_frame_o |-> in_stall_o)
    else $error("input accepted in the middle of a payload burst");

  // An empty frame gives a single zero beat.
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PAYLOAD_MAX < 64) && out_valid_o && (payload_length_o == 6'd0)
      |-> last_of_frame_o && (payload_byte_o == 8'd0))
    else $error("empty frame gave a malformed beat");

  // A stalled input beat stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(rx_byte_i))
    else $error("stalled input beat changed");

endmodule

bind stuffed_frame_receiver_crc16 sfr_checker #(
  .PAYLOAD_MAX(PAYLOAD_MAX)
) u_sfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .rx_byte_i       (rx_byte_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .source_address_o(source_address_o),
  .source_port_o   (source_port_o),
  .payload_length_o(payload_length_o),
  .payload_byte_o  (payload_byte_o),
  .last_of_frame_o (last_of_frame_o)
);
